[hdl/pfa_pkg.sv]
// Shared types and constants for the partition fit allocator.
// No dependencies; used by pfa_table and partition_fit_allocator.

package pfa_pkg;

    localparam int DEF_NUM_PARTITIONS = 64;
    localparam int DEF_SIZE_BITS      = 16;

    localparam int FUNC_W     = 2;
    localparam int SLOT_W     = 6;
    localparam int AMOUNT_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int POLICY_W   = 2;
    localparam int PIU_W      = 7;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_ALLOC = 2'd2
    } func_t;

    typedef enum logic [POLICY_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } policy_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIT_POLICY       = 1'b0,
        REG_PARTITIONS_IN_USE = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'd0,
        ST_IDLE  = 3'd1,
        ST_SCAN  = 3'd2,
        ST_DRAIN = 3'd3,
        ST_RESP  = 3'd4
    } state_t;

    // table access controls from the sequencer
    typedef struct packed {
        logic rd;
        logic size_we;
        logic occ_we;
        logic occ_bit;
    } tbl_ctrl_t;

endpackage

[hdl/pfa_table.sv]
// Partition size memory and occupied-mark memory, registered read.
// Depends on pfa_pkg (tbl_ctrl_t).

module pfa_table #(
    parameter int NUM_PARTITIONS = pfa_pkg::DEF_NUM_PARTITIONS,
    parameter int SIZE_BITS      = pfa_pkg::DEF_SIZE_BITS,
    localparam int IDX_W         = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1
) (
    input  logic                   clk,
    input  pfa_pkg::tbl_ctrl_t     ctrl,
    input  logic [IDX_W-1:0]       rd_addr,
    input  logic [IDX_W-1:0]       wr_addr,
    input  logic [SIZE_BITS-1:0]   size_wdata,
    output logic [SIZE_BITS-1:0]   rd_size,
    output logic                   rd_occ
);

    logic [SIZE_BITS-1:0] size_mem [NUM_PARTITIONS];
    logic                 occ_mem  [NUM_PARTITIONS];
    logic [SIZE_BITS-1:0] rd_size_reg;
    logic                 rd_occ_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.size_we)
        begin
            size_mem[wr_addr] <= size_wdata;
        end
        if (ctrl.occ_we)
        begin
            occ_mem[wr_addr] <= ctrl.occ_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd)
        begin
            rd_size_reg <= size_mem[rd_addr];
            rd_occ_reg  <= occ_mem[rd_addr];
        end
    end

    assign rd_size = rd_size_reg;
    assign rd_occ  = rd_occ_reg;

endmodule

[hdl/partition_fit_allocator.sv]
// Partition fit allocator top level: sequencer, search datapath, config, result register.
// Depends on pfa_pkg and pfa_table.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------
//  in      | in  | in_valid/in_stall  | func, slot, amount
//  out     | out | out_valid/out_stall| granted, chosen_slot, leftover
//  cfg     | in  | cfg_we             | cfg_index, cfg_data
//
//  Load: size written at the accepting edge. Clear: all NUM_PARTITIONS marks cleared,
//  one occupied mark written per cycle. Allocate: states scan (n reads), drain and
//  response, which loads the result register; scan and drain are skipped when n is zero; n = active
//  partitions, every request scans all n entries through the one-read-per-cycle table port.
//  After reset all NUM_PARTITIONS occupied marks are swept; in_stall is high.
//  in_stall is high while an item is in work; a held result only blocks loading the next result.

module partition_fit_allocator #(
    parameter int NUM_PARTITIONS = pfa_pkg::DEF_NUM_PARTITIONS,
    parameter int SIZE_BITS      = pfa_pkg::DEF_SIZE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [pfa_pkg::FUNC_W-1:0]       func,
    input  logic [pfa_pkg::SLOT_W-1:0]       slot,
    input  logic [pfa_pkg::AMOUNT_W-1:0]     amount,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             granted,
    output logic [pfa_pkg::SLOT_W-1:0]       chosen_slot,
    output logic [pfa_pkg::AMOUNT_W-1:0]     leftover,
    input  logic                             cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);

    pfa_pkg::state_t     state_reg, state_next;
    pfa_pkg::policy_t    policy_reg;
    logic [pfa_pkg::PIU_W-1:0] piu_reg;

    logic [IDX_W-1:0]     clr_reg, clr_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic [IDX_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     addr_reg, addr_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] best_size_reg, best_size_next;
    logic [SIZE_BITS-1:0] req_reg, req_next;

    logic                           out_valid_reg, out_valid_next;
    logic                           granted_reg, granted_next;
    logic [pfa_pkg::SLOT_W-1:0]     chosen_reg, chosen_next;
    logic [pfa_pkg::AMOUNT_W-1:0]   leftover_reg, leftover_next;

    pfa_pkg::tbl_ctrl_t   ctrl;
    logic [IDX_W-1:0]     wr_addr;
    logic [SIZE_BITS-1:0] rd_size;
    logic                 rd_occ;

    logic [CNT_W-1:0]     n_act;
    logic [IDX_W-1:0]     last_idx;
    logic                 accept;
    logic                 out_free;
    logic                 slot_ok;
    logic                 fits;
    logic                 take;
    pfa_pkg::func_t       func_in;

    assign func_in  = pfa_pkg::func_t'(func);
    assign n_act    = (int'(piu_reg) > NUM_PARTITIONS) ? CNT_W'(NUM_PARTITIONS)
                                                       : CNT_W'(piu_reg);
    assign last_idx = IDX_W'(n_act - 1'b1);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign slot_ok  = (32'(slot) < NUM_PARTITIONS);

    // evaluate the entry returned by the previous read
    assign fits = !rd_occ && (rd_size >= req_reg);
    always_comb
    begin
        take = 1'b0;
        if (rd_valid_reg && fits)
        begin
            case (policy_reg)
                pfa_pkg::FIT_BEST:  take = !found_reg || (rd_size < best_size_reg);
                pfa_pkg::FIT_WORST: take = !found_reg || (rd_size > best_size_reg);
                default:            take = !found_reg;
            endcase
        end
    end

    pfa_table #(
        .NUM_PARTITIONS (NUM_PARTITIONS),
        .SIZE_BITS      (SIZE_BITS)
    ) u_table (
        .clk        (clk),
        .ctrl       (ctrl),
        .rd_addr    (addr_reg),
        .wr_addr    (wr_addr),
        .size_wdata (SIZE_BITS'(amount)),
        .rd_size    (rd_size),
        .rd_occ     (rd_occ)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfa_pkg::ST_CLEAR:
            begin
                if (clr_reg == IDX_W'(NUM_PARTITIONS - 1))
                begin
                    state_next = pfa_pkg::ST_IDLE;
                end
            end
            pfa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (func_in)
                        pfa_pkg::FUNC_CLEAR: state_next = pfa_pkg::ST_CLEAR;
                        pfa_pkg::FUNC_ALLOC: state_next = (n_act == '0) ? pfa_pkg::ST_RESP
                                                                         : pfa_pkg::ST_SCAN;
                        default:             state_next = pfa_pkg::ST_IDLE;
                    endcase
                end
            end
            pfa_pkg::ST_SCAN:
            begin
                if (cnt_reg == last_idx)
                begin
                    state_next = pfa_pkg::ST_DRAIN;
                end
            end
            pfa_pkg::ST_DRAIN:
            begin
                state_next = pfa_pkg::ST_RESP;
            end
            pfa_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = pfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfa_pkg::ST_CLEAR;
            end
        endcase
    end

    // state outputs: handshake and table access
    always_comb
    begin
        in_stall     = 1'b1;
        ctrl         = '0;
        wr_addr      = '0;
        unique case (state_reg)
            pfa_pkg::ST_CLEAR:
            begin
                ctrl.occ_we = 1'b1;
                wr_addr     = clr_reg;
            end
            pfa_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && (func_in == pfa_pkg::FUNC_LOAD) && slot_ok)
                begin
                    ctrl.size_we = 1'b1;
                    wr_addr      = IDX_W'(slot);
                end
            end
            pfa_pkg::ST_SCAN:
            begin
                ctrl.rd = 1'b1;
            end
            pfa_pkg::ST_DRAIN:
            begin
                ctrl.rd = 1'b0;
            end
            pfa_pkg::ST_RESP:
            begin
                if (out_free && found_reg)
                begin
                    ctrl.occ_we  = 1'b1;
                    ctrl.occ_bit = 1'b1;
                    wr_addr      = pick_reg;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        clr_next       = clr_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        rd_idx_next    = rd_idx_reg;
        rd_valid_next  = 1'b0;
        found_next     = found_reg;
        pick_next      = pick_reg;
        best_size_next = best_size_reg;
        req_next       = req_reg;
        out_valid_next = out_valid_reg && out_stall;
        granted_next   = granted_reg;
        chosen_next    = chosen_reg;
        leftover_next  = leftover_reg;

        if (state_reg == pfa_pkg::ST_CLEAR)
        begin
            clr_next = clr_reg + 1'b1;
        end

        if (accept && (func_in == pfa_pkg::FUNC_CLEAR))
        begin
            clr_next = '0;
            ptr_next = '0;
        end

        if (accept && (func_in == pfa_pkg::FUNC_ALLOC))
        begin
            req_next   = SIZE_BITS'(amount);
            found_next = 1'b0;
            cnt_next   = '0;
            // next fit starts at the pointer unless it lies past the active range
            if ((policy_reg == pfa_pkg::FIT_NEXT) && (CNT_W'(ptr_reg) < n_act))
            begin
                addr_next = ptr_reg;
            end
            else
            begin
                addr_next = '0;
            end
        end

        if (state_reg == pfa_pkg::ST_SCAN)
        begin
            rd_valid_next = 1'b1;
            rd_idx_next   = addr_reg;
            cnt_next      = cnt_reg + 1'b1;
            addr_next     = (addr_reg == last_idx) ? '0 : addr_reg + 1'b1;
        end

        if (take)
        begin
            found_next     = 1'b1;
            pick_next      = rd_idx_reg;
            best_size_next = rd_size;
        end

        if ((state_reg == pfa_pkg::ST_RESP) && out_free)
        begin
            out_valid_next = 1'b1;
            granted_next   = found_reg;
            if (found_reg)
            begin
                ptr_next      = pick_reg;
                chosen_next   = pfa_pkg::SLOT_W'(pick_reg);
                leftover_next = pfa_pkg::AMOUNT_W'(best_size_reg - req_reg);
            end
            else
            begin
                chosen_next   = '0;
                leftover_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfa_pkg::ST_CLEAR;
            clr_reg       <= '0;
            ptr_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            ptr_reg       <= ptr_next;
            rd_valid_reg  <= rd_valid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        addr_reg      <= addr_next;
        rd_idx_reg    <= rd_idx_next;
        pick_reg      <= pick_next;
        best_size_reg <= best_size_next;
        req_reg       <= req_next;
        granted_reg   <= granted_next;
        chosen_reg    <= chosen_next;
        leftover_reg  <= leftover_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= pfa_pkg::FIT_FIRST;
            piu_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (pfa_pkg::reg_idx_t'(cfg_index))
                pfa_pkg::REG_FIT_POLICY:
                begin
                    policy_reg <= pfa_pkg::policy_t'(cfg_data[pfa_pkg::POLICY_W-1:0]);
                end
                pfa_pkg::REG_PARTITIONS_IN_USE:
                begin
                    piu_reg <= cfg_data[pfa_pkg::PIU_W-1:0];
                end
                default:
                begin
                    piu_reg <= piu_reg;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign granted     = granted_reg;
    assign chosen_slot = chosen_reg;
    assign leftover    = leftover_reg;

    // table is read only while a search runs
    a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pfa_pkg::ST_SCAN || state_reg == pfa_pkg::ST_DRAIN)
            |-> !(ctrl.size_we || ctrl.occ_we))
        else $error("table write during search");

    a_rd_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == pfa_pkg::ST_SCAN))
        else $error("read data flagged without a scan read");

    a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && granted_reg) |-> (CNT_W'(pick_reg) < n_act))
        else $error("granted partition outside active range");

    a_refusal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !granted_reg) |-> (chosen_reg == '0 && leftover_reg == '0))
        else $error("refused beat carries index or leftover");

endmodule
